/* rtl/lbq_pkg.sv */
// lbq_pkg: shared constants, codes and state type of the level bucket queue
`timescale 1ns / 1ps

package lbq_pkg;

    // defaults for the top level parameters
    localparam int LBQ_LEVELS       = 64;
    localparam int LBQ_CAPACITY     = 1024;
    localparam int LBQ_HANDLE_WIDTH = 16;

    // fixed field widths
    localparam int LBQ_LEVEL_W  = 6;
    localparam int LBQ_OP_W     = 2;
    localparam int LBQ_STATUS_W = 2;

    localparam logic [LBQ_LEVEL_W-1:0] LBQ_TOP_LEVEL_RST = 6'd63;

    typedef enum logic [LBQ_OP_W-1:0] {
        OP_PUT     = 2'd0,
        OP_GET_MIN = 2'd1,
        OP_GET_MAX = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [LBQ_STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2,
        STS_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUT_LINK,
        ST_GET_HEAD,
        ST_GET_POP
    } t_state;

endpackage

/* rtl/level_bucket_queue.sv */
// level_bucket_queue: bucket priority queue with one fifo bucket per level
`timescale 1ns / 1ps

// usage
// - request channel: raise start with operation, node_handle and node_level; the request is
//   taken at the clock edge where start is high and busy is low
// - operations: put appends a handle to the bucket of its level, get-min pops the oldest
//   handle of the lowest non-empty level, get-max the oldest of the highest non-empty level
// - result channel: o_valid is high for exactly one cycle with o_found, o_handle_out and
//   o_status; the receiver cannot stall, so a result must be taken when it shows
// - refused put, get on an empty queue, unused code: answered from idle with the result
//   registered in the next cycle, busy stays low; an accepted put passes through put_link,
//   a get through get_head and then get_pop, before its result is registered
// - busy holds off a new request until the current one is done; the bucket table
//   (head/tail per level) and the node table (handle/link per entry) are synchronous
//   memories with registered reads, and a get walks bucket table then node table
// - free slots come first from a fill counter and then from a linked free list of
//   released slots, so no clearing pass over the node table is needed
// - top_level: user writes i_cfg_we / i_cfg_wdata only while no request is in flight (unenforced)
// - reset (synchronous, active low) empties the queue and sets top_level to 63
module level_bucket_queue
    import lbq_pkg::*;
#(
    parameter int LEVELS       = LBQ_LEVELS,
    parameter int CAPACITY     = LBQ_CAPACITY,
    parameter int HANDLE_WIDTH = LBQ_HANDLE_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    start,
    output logic                    busy,
    input  logic [LBQ_OP_W-1:0]     i_operation,
    input  logic [HANDLE_WIDTH-1:0] i_node_handle,
    input  logic [LBQ_LEVEL_W-1:0]  i_node_level,
    // result channel
    output logic                    o_valid,
    output logic                    o_found,
    output logic [HANDLE_WIDTH-1:0] o_handle_out,
    output logic [LBQ_STATUS_W-1:0] o_status,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [LBQ_LEVEL_W-1:0]  i_cfg_wdata
);

    localparam int LW = $clog2(LEVELS);        // level index width
    localparam int PW = $clog2(CAPACITY);      // slot pointer width
    localparam int CW = $clog2(CAPACITY + 1);  // entry count width

    typedef struct packed {
        logic [HANDLE_WIDTH-1:0] handle;
        logic [PW-1:0]           link;
    } t_node;

    typedef struct packed {
        logic [PW-1:0] head;
        logic [PW-1:0] tail;
    } t_bucket;

    // memories
    t_node   r_node_mem [CAPACITY];
    t_bucket r_bkt_mem  [LEVELS];
    t_node   r_node_rd;
    t_bucket r_bkt_rd;

    // control state
    t_state              r_state, n_state;
    logic [LEVELS-1:0]   r_nonempty, n_nonempty;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_fill, n_fill;
    logic [PW-1:0]       r_free_head, n_free_head;
    logic [LW-1:0]       r_low, n_low;
    logic [LW-1:0]       r_high, n_high;
    logic [LBQ_LEVEL_W-1:0] r_top_level;
    logic                r_valid, n_valid;

    // per request payload
    logic [LW-1:0]       r_lv, n_lv;
    logic [PW-1:0]       r_slot, n_slot;
    logic                r_from_free, n_from_free;
    logic                r_put_ne, n_put_ne;
    logic                r_is_min, n_is_min;
    logic                r_last, n_last;
    logic                r_found, n_found;
    logic [HANDLE_WIDTH-1:0] r_handle_out, n_handle_out;
    t_status             r_status, n_status;

    // memory ports
    logic [PW-1:0]       w_node_raddr, w_node_waddr;
    logic                w_node_we_h, w_node_we_l;
    logic [HANDLE_WIDTH-1:0] w_node_wh;
    logic [PW-1:0]       w_node_wl;
    logic [LW-1:0]       w_bkt_raddr, w_bkt_waddr;
    logic                w_bkt_we;
    t_bucket             w_bkt_wdata;

    // request decode
    t_op                 w_op;
    logic [LW-1:0]       w_put_lv;
    logic                w_range_err;
    logic                w_full;
    logic                w_fill_left;
    logic [PW-1:0]       w_alloc;
    logic [LEVELS-1:0]   w_ones;
    logic [LEVELS-1:0]   w_min_mask, w_max_mask;
    logic [LW-1:0]       w_min_lv, w_max_lv;

    assign busy = (r_state != ST_IDLE);

    assign w_op        = t_op'(i_operation);
    assign w_put_lv    = LW'(i_node_level);
    assign w_range_err = (i_node_level > r_top_level) || (32'(i_node_level) >= LEVELS);
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_fill_left = (r_fill != CW'(CAPACITY));
    // untouched slots first, then released ones
    assign w_alloc     = w_fill_left ? r_fill[PW-1:0] : r_free_head;

    // the bounds never cut off a live level: low is at most the lowest, high at least the highest
    assign w_ones     = '1;
    assign w_min_mask = r_nonempty & (w_ones << r_low);
    assign w_max_mask = r_nonempty & (w_ones >> (LW'(LEVELS - 1) - r_high));

    // lowest set level
    always_comb begin
        w_min_lv = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (w_min_mask[i]) begin
                w_min_lv = LW'(i);
            end
        end
    end

    // highest set level
    always_comb begin
        w_max_lv = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (w_max_mask[i]) begin
                w_max_lv = LW'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (w_op)
                        OP_PUT: begin
                            if (!w_range_err && !w_full) begin
                                n_state = ST_PUT_LINK;
                            end
                        end
                        OP_GET_MIN, OP_GET_MAX: begin
                            if (r_count != '0) begin
                                n_state = ST_GET_HEAD;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PUT_LINK: n_state = ST_IDLE;
            ST_GET_HEAD: n_state = ST_GET_POP;
            ST_GET_POP:  n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // datapath, memory controls and results
    always_comb begin
        n_nonempty   = r_nonempty;
        n_count      = r_count;
        n_fill       = r_fill;
        n_free_head  = r_free_head;
        n_low        = r_low;
        n_high       = r_high;
        n_lv         = r_lv;
        n_slot       = r_slot;
        n_from_free  = r_from_free;
        n_put_ne     = r_put_ne;
        n_is_min     = r_is_min;
        n_last       = r_last;
        n_valid      = 1'b0;
        n_found      = 1'b0;
        n_handle_out = '0;
        n_status     = STS_OK;

        w_node_raddr = r_free_head;
        w_node_waddr = r_slot;
        w_node_we_h  = 1'b0;
        w_node_we_l  = 1'b0;
        w_node_wh    = i_node_handle;
        w_node_wl    = r_slot;
        w_bkt_raddr  = r_lv;
        w_bkt_waddr  = r_lv;
        w_bkt_we     = 1'b0;
        w_bkt_wdata  = r_bkt_rd;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (w_op)
                        OP_PUT: begin
                            if (w_range_err) begin
                                n_valid  = 1'b1;
                                n_status = STS_RANGE;
                            end else if (w_full) begin
                                n_valid  = 1'b1;
                                n_status = STS_FULL;
                            end else begin
                                // store the handle now, fetch free link and bucket
                                w_node_we_h  = 1'b1;
                                w_node_waddr = w_alloc;
                                w_bkt_raddr  = w_put_lv;
                                n_lv         = w_put_lv;
                                n_slot       = w_alloc;
                                n_from_free  = !w_fill_left;
                                n_put_ne     = r_nonempty[w_put_lv];
                            end
                        end
                        OP_GET_MIN, OP_GET_MAX: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = STS_EMPTY;
                            end else begin
                                n_is_min    = (w_op == OP_GET_MIN);
                                n_lv        = (w_op == OP_GET_MIN) ? w_min_lv : w_max_lv;
                                w_bkt_raddr = (w_op == OP_GET_MIN) ? w_min_lv : w_max_lv;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end

            ST_PUT_LINK: begin
                if (r_from_free) begin
                    n_free_head = r_node_rd.link;
                end else begin
                    n_fill = r_fill + 1'b1;
                end
                w_bkt_we = 1'b1;
                if (r_put_ne) begin
                    // chain behind the old tail
                    w_node_we_l      = 1'b1;
                    w_node_waddr     = r_bkt_rd.tail;
                    w_node_wl        = r_slot;
                    w_bkt_wdata.head = r_bkt_rd.head;
                    w_bkt_wdata.tail = r_slot;
                end else begin
                    w_bkt_wdata.head = r_slot;
                    w_bkt_wdata.tail = r_slot;
                end
                n_nonempty[r_lv] = 1'b1;
                if (r_count == '0) begin
                    n_low  = r_lv;
                    n_high = r_lv;
                end else begin
                    if (r_lv < r_low) begin
                        n_low = r_lv;
                    end
                    if (r_lv > r_high) begin
                        n_high = r_lv;
                    end
                end
                n_count = r_count + 1'b1;
                n_valid = 1'b1;
                n_found = 1'b1;
            end

            ST_GET_HEAD: begin
                // read the head node and push its slot on the free list
                w_node_raddr = r_bkt_rd.head;
                w_node_we_l  = 1'b1;
                w_node_waddr = r_bkt_rd.head;
                w_node_wl    = r_free_head;
                n_free_head  = r_bkt_rd.head;
                n_count      = r_count - 1'b1;
                n_last       = (r_bkt_rd.head == r_bkt_rd.tail);
                if (r_bkt_rd.head == r_bkt_rd.tail) begin
                    n_nonempty[r_lv] = 1'b0;
                end
                if (r_is_min) begin
                    n_low = r_lv;
                end else begin
                    n_high = r_lv;
                end
            end

            ST_GET_POP: begin
                if (!r_last) begin
                    w_bkt_we         = 1'b1;
                    w_bkt_wdata.head = r_node_rd.link;
                    w_bkt_wdata.tail = r_bkt_rd.tail;
                end
                n_valid      = 1'b1;
                n_found      = 1'b1;
                n_handle_out = r_node_rd.handle;
            end

            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_nonempty  <= '0;
            r_count     <= '0;
            r_fill      <= '0;
            r_free_head <= '0;
            r_low       <= '0;
            r_high      <= '0;
            r_top_level <= LBQ_TOP_LEVEL_RST;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nonempty  <= n_nonempty;
            r_count     <= n_count;
            r_fill      <= n_fill;
            r_free_head <= n_free_head;
            r_low       <= n_low;
            r_high      <= n_high;
            r_valid     <= n_valid;
            if (i_cfg_we) begin
                r_top_level <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lv         <= n_lv;
        r_slot       <= n_slot;
        r_from_free  <= n_from_free;
        r_put_ne     <= n_put_ne;
        r_is_min     <= n_is_min;
        r_last       <= n_last;
        r_found      <= n_found;
        r_handle_out <= n_handle_out;
        r_status     <= n_status;
    end

    // node table: handle and link per slot, field write enables
    always_ff @(posedge i_clk) begin
        r_node_rd <= r_node_mem[w_node_raddr];
        if (w_node_we_h) begin
            r_node_mem[w_node_waddr].handle <= w_node_wh;
        end
        if (w_node_we_l) begin
            r_node_mem[w_node_waddr].link <= w_node_wl;
        end
    end

    // bucket table: head and tail per level
    always_ff @(posedge i_clk) begin
        r_bkt_rd <= r_bkt_mem[w_bkt_raddr];
        if (w_bkt_we) begin
            r_bkt_mem[w_bkt_waddr] <= w_bkt_wdata;
        end
    end

    assign o_valid      = r_valid;
    assign o_found      = r_found;
    assign o_handle_out = r_handle_out;
    assign o_status     = r_status;

    // checks
    a_count_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_nonempty == '0))
        else $error("entry count and bucket mask disagree");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(CAPACITY)) && (r_fill <= CW'(CAPACITY)))
        else $error("entry count or fill counter past capacity");

    a_get_level_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GET_HEAD) |-> r_nonempty[r_lv])
        else $error("get served an empty level");

    a_put_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUT_LINK) |-> (r_count != CW'(CAPACITY)))
        else $error("put linked while full");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GET_POP) |=> (o_valid && o_found))
        else $error("pop did not deliver a result");

endmodule
